// ===== src/lzwd_pkg.sv =====
// Package for the LZW decoder: code constants, widths and table sizes.
// No dependencies; imported by the top level of the decoder.
`timescale 1ns / 1ps
package lzwd_pkg;

  localparam int unsigned MaxCodeBits  = 12;
  localparam int unsigned DictAddrW    = 12;
  localparam int unsigned StackAddrW   = 12;
  localparam int unsigned StackEntries = 4096;
  localparam int unsigned DictEntries  = 4096;

  localparam logic [11:0] CodeClear = 12'h100;
  localparam logic [11:0] CodeEnd   = 12'h101;
  localparam logic [12:0] FirstFree = 13'h102;
  localparam logic [12:0] FirstBump = 13'h200;
  localparam logic [3:0]  FirstWidth = 4'd9;

  localparam logic [0:0] CmdOffer = 1'b0;
  localparam logic [0:0] CmdPull  = 1'b1;

endpackage

// ===== src/lzwd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the dictionary tables and the expansion stack.
`timescale 1ns / 1ps
module lzwd_ram #(
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lzw_variable_width_decompressor_unit.sv =====
// Top level of the LZW decoder with 9 to 12 bit codes.
// Depends on lzwd_pkg and instantiates lzwd_ram for the tables and the stack.
`timescale 1ns / 1ps
// How to use this block:
// A word enters on the input channel (in_valid_i / in_ready_o) and carries a
// command. An offer (command 0) hands in one compressed byte; it is taken
// into a 24-bit bit buffer when the stream is not finished and at most 16
// bits are buffered. A pull (command 1) returns one decoded byte if one can
// be produced. Every accepted word yields exactly one result word on the
// output channel (res_valid_o / res_ready_i), held in an output register.
// An offer answers in the cycle after it is taken. A pull that finds the
// expansion stack non-empty answers through the check, stack read and
// result steps. A pull that must decode a code also takes code setup and
// completion, and each dictionary chain step is one registered read of
// the prefix and suffix memories; the chain walk is the limiting loop.
// Only one word is in work at a time; in_ready_o is low while a pull decodes.
// A new word is taken when the output register is empty or being drained in
// the same cycle, so a stalled receiver holds off the input channel.
// Reset clears the bit buffer, code width, dictionary counters, stack depth
// and finished flag at once; memories are not cleared, since decoding only
// reads dictionary entries and stack slots that were written before.
module lzw_variable_width_decompressor_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic [7:0] in_byte_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic       accepted_o,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       finished_o
);
  import lzwd_pkg::*;

  // Sequencer states.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StWalk  = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StPop   = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [23:0] buf_q, buf_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [3:0]  width_q, width_d;
  logic [12:0] nfc_q, nfc_d;
  logic [12:0] bump_q, bump_d;
  logic [11:0] prev_q, prev_d;
  logic [7:0]  lfc_q, lfc_d;
  logic        aclr_q, aclr_d;
  logic        done_q, done_d;
  logic [12:0] depth_q, depth_d;
  logic [11:0] walk_q, walk_d;
  logic [11:0] cur_q, cur_d;

  logic        rv_q, rv_d;
  logic        racc_q, racc_d;
  logic        rov_q, rov_d;
  logic [7:0]  rbyte_q, rbyte_d;
  logic        rfin_q, rfin_d;

  // Memory ports.
  logic        dict_we, dict_re;
  logic [11:0] dict_waddr, dict_raddr, pre_wdata, pre_rdata;
  logic [7:0]  suf_wdata, suf_rdata;
  logic        stk_we, stk_re;
  logic [11:0] stk_waddr, stk_raddr;
  logic [7:0]  stk_wdata, stk_rdata;

  logic [11:0] code;
  logic [11:0] code_mask;
  logic [12:0] nfc_inc;
  logic        accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (st_q == StIdle) && (!rv_q || res_ready_i);

  assign code_mask = 12'((13'd1 << width_q) - 13'd1);
  assign code      = buf_q[11:0] & code_mask;
  assign nfc_inc   = nfc_q + 13'd1;

  always_comb begin
    st_d    = st_q;
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    width_d = width_q;
    nfc_d   = nfc_q;
    bump_d  = bump_q;
    prev_d  = prev_q;
    lfc_d   = lfc_q;
    aclr_d  = aclr_q;
    done_d  = done_q;
    depth_d = depth_q;
    walk_d  = walk_q;
    cur_d   = cur_q;

    rv_d    = rv_q && !res_ready_i;
    racc_d  = racc_q;
    rov_d   = rov_q;
    rbyte_d = rbyte_q;
    rfin_d  = rfin_q;

    dict_we    = 1'b0;
    dict_waddr = nfc_q[11:0];
    pre_wdata  = prev_q;
    suf_wdata  = walk_q[7:0];
    dict_re    = 1'b0;
    dict_raddr = walk_q;
    stk_we     = 1'b0;
    stk_waddr  = depth_q[11:0];
    stk_wdata  = 8'd0;
    stk_re     = 1'b0;
    stk_raddr  = 12'(depth_q - 13'd1);

    case (st_q)
      StIdle: begin
        if (accept) begin
          if (command_i == CmdOffer) begin
            rv_d    = 1'b1;
            rov_d   = 1'b0;
            rbyte_d = 8'd0;
            racc_d  = 1'b0;
            if (!done_q && cnt_q <= 5'd16) begin
              buf_d  = buf_q | (24'(in_byte_i) << cnt_q);
              cnt_d  = cnt_q + 5'd8;
              racc_d = 1'b1;
            end
            rfin_d = done_q;
          end else begin
            st_d = StCheck;
          end
        end
      end
      StCheck: begin
        if (depth_q == 13'd0 && !done_q && cnt_q >= 5'(width_q)) begin
          buf_d = buf_q >> width_q;
          cnt_d = cnt_q - 5'(width_q);
          if (aclr_q) begin
            aclr_d = 1'b0;
            if (code == CodeEnd) begin
              done_d = 1'b1;
            end else begin
              // First code after a clear is a literal, even the clear code.
              prev_d    = code;
              lfc_d     = code[7:0];
              stk_we    = 1'b1;
              stk_wdata = code[7:0];
              depth_d   = depth_q + 13'd1;
            end
          end else if (code == CodeEnd) begin
            done_d = 1'b1;
          end else if (code == CodeClear) begin
            width_d = FirstWidth;
            bump_d  = FirstBump;
            nfc_d   = FirstFree;
            aclr_d  = 1'b1;
          end else begin
            cur_d  = code;
            walk_d = code;
            if ({1'b0, code} >= nfc_q) begin
              // Code not yet in the dictionary: the KwKwK case.
              stk_we    = 1'b1;
              stk_wdata = lfc_q;
              depth_d   = depth_q + 13'd1;
              walk_d    = prev_q;
            end
            st_d = StWalk;
          end
        end else if (depth_q != 13'd0) begin
          stk_re  = 1'b1;
          depth_d = depth_q - 13'd1;
          st_d    = StPop;
        end else begin
          rv_d    = 1'b1;
          racc_d  = 1'b0;
          rov_d   = 1'b0;
          rbyte_d = 8'd0;
          rfin_d  = done_q;
          st_d    = StIdle;
        end
      end
      StWalk: begin
        if (walk_q >= 12'd256 && depth_q < 13'(StackEntries - 1)) begin
          dict_re = 1'b1;
          st_d    = StRead;
        end else begin
          lfc_d = walk_q[7:0];
          if (depth_q < 13'(StackEntries)) begin
            stk_we    = 1'b1;
            stk_wdata = walk_q[7:0];
            depth_d   = depth_q + 13'd1;
          end
          if (nfc_q < 13'(DictEntries)) begin
            dict_we = 1'b1;
            nfc_d   = nfc_inc;
          end
          prev_d = cur_q;
          if (nfc_d >= bump_q && width_q < 4'(MaxCodeBits)) begin
            width_d = width_q + 4'd1;
            bump_d  = bump_q << 1;
          end
          st_d = StCheck;
        end
      end
      StRead: begin
        stk_we    = 1'b1;
        stk_wdata = suf_rdata;
        depth_d   = depth_q + 13'd1;
        walk_d    = pre_rdata;
        st_d      = StWalk;
      end
      StPop: begin
        rv_d    = 1'b1;
        racc_d  = 1'b0;
        rov_d   = 1'b1;
        rbyte_d = stk_rdata;
        rfin_d  = done_q;
        st_d    = StIdle;
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      buf_q   <= 24'd0;
      cnt_q   <= 5'd0;
      width_q <= FirstWidth;
      nfc_q   <= FirstFree;
      bump_q  <= FirstBump;
      prev_q  <= 12'd0;
      lfc_q   <= 8'd0;
      aclr_q  <= 1'b0;
      done_q  <= 1'b0;
      depth_q <= 13'd0;
      rv_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      buf_q   <= buf_d;
      cnt_q   <= cnt_d;
      width_q <= width_d;
      nfc_q   <= nfc_d;
      bump_q  <= bump_d;
      prev_q  <= prev_d;
      lfc_q   <= lfc_d;
      aclr_q  <= aclr_d;
      done_q  <= done_d;
      depth_q <= depth_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q  <= walk_d;
    cur_q   <= cur_d;
    racc_q  <= racc_d;
    rov_q   <= rov_d;
    rbyte_q <= rbyte_d;
    rfin_q  <= rfin_d;
  end

  lzwd_ram #(.ADDR_W(DictAddrW), .DATA_W(12)) u_prefix (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (dict_waddr),
    .wdata_i (pre_wdata),
    .re_i    (dict_re),
    .raddr_i (dict_raddr),
    .rdata_o (pre_rdata)
  );

  lzwd_ram #(.ADDR_W(DictAddrW), .DATA_W(8)) u_suffix (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (dict_waddr),
    .wdata_i (suf_wdata),
    .re_i    (dict_re),
    .raddr_i (dict_raddr),
    .rdata_o (suf_rdata)
  );

  lzwd_ram #(.ADDR_W(StackAddrW), .DATA_W(8)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign res_valid_o = rv_q;
  assign accepted_o  = racc_q;
  assign out_valid_o = rov_q;
  assign out_byte_o  = rbyte_q;
  assign finished_o  = rfin_q;

`ifndef SYNTHESIS
  // Once the end code is seen the stream stays finished until reset.
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(done_q))
    else $error("finished flag dropped");

  // A result never reports both a taken offer and a decoded byte.
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(accepted_o && out_valid_o))
    else $error("result is both offer and pull");

  // The stack never grows past its capacity.
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= 13'(StackEntries))
    else $error("stack overflow");

  // The code width stays within 9 to 12 bits and the buffer within 24 bits.
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (width_q >= FirstWidth) && (width_q <= 4'(MaxCodeBits)) && (cnt_q <= 5'd24))
    else $error("code width or bit count out of range");
`endif

endmodule

// ===== sim/tb_lzw_variable_width_decompressor_unit.sv =====
// Testbench for the LZW decoder top level: builds well-formed compressed code
// streams, predicts every result word and checks the output channel.
// Depends on lzwd_pkg and lzw_variable_width_decompressor_unit.
`timescale 1ns / 1ps
module tb_lzw_variable_width_decompressor_unit;
  import lzwd_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } word_in_t;

  typedef struct packed {
    logic       accepted;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       finished;
  } word_out_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       command;
  logic [7:0] in_byte;
  logic       res_valid;
  logic       res_ready;
  logic       accepted;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       finished;

  lzw_variable_width_decompressor_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .command_i  (command),
    .in_byte_i  (in_byte),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .accepted_o (accepted),
    .out_valid_o(out_valid),
    .out_byte_o (out_byte),
    .finished_o (finished)
  );

  // Words waiting to be driven, and the results they are predicted to give.
  word_in_t  pending_words[$];
  word_out_t expected_words[$];
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        stall_left = 0;

  // Decoder state as predicted, updated word by word at queueing time.
  logic [23:0] dec_buf;
  int          dec_count;
  int          dec_width;
  int          dec_next_free;
  int          dec_bump;
  int          dec_prev;
  logic [7:0]  dec_first_char;
  bit          dec_after_clear;
  bit          dec_done;
  logic [11:0] dec_prefix[DictEntries];
  logic [7:0]  dec_suffix[DictEntries];
  logic [7:0]  dec_stack[StackEntries];
  int          dec_depth;

  // Code generator state: it mirrors the decoder's dictionary counters so that
  // it knows the code width and never names an entry past the next free one.
  int          gen_width = FirstWidth;
  int          gen_next_free = FirstFree;
  int          gen_bump = FirstBump;
  bit          gen_after_clear = 0;
  logic [31:0] pack_bits = 0;
  int          pack_count = 0;
  logic [7:0]  stream_bytes[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_stack(logic [7:0] value);
    if (dec_depth < StackEntries) begin
      dec_stack[dec_depth] = value;
      dec_depth++;
    end
  endfunction

  function automatic void decode_code();
    int code;
    int walk;
    logic [7:0] root;
    code = int'(dec_buf & ((24'd1 << dec_width) - 24'd1));
    dec_buf = dec_buf >> dec_width;
    dec_count -= dec_width;
    if (dec_after_clear) begin
      dec_after_clear = 0;
      if (code == CodeEnd) begin
        dec_done = 1;
        return;
      end
      dec_prev = code;
      dec_first_char = code[7:0];
      push_stack(code[7:0]);
      return;
    end
    if (code == CodeEnd) begin
      dec_done = 1;
      return;
    end
    if (code == CodeClear) begin
      dec_width = FirstWidth;
      dec_bump = FirstBump;
      dec_next_free = FirstFree;
      dec_after_clear = 1;
      return;
    end
    walk = code;
    // KwKwK: the code is not in the dictionary yet, so it expands to the
    // previous string followed by that string's first character.
    if (walk >= dec_next_free) begin
      push_stack(dec_first_char);
      walk = dec_prev;
    end
    while (walk >= 256 && dec_depth < StackEntries - 1) begin
      push_stack(dec_suffix[walk % DictEntries]);
      walk = dec_prefix[walk % DictEntries];
    end
    root = walk[7:0];
    dec_first_char = root;
    push_stack(root);
    if (dec_next_free < DictEntries) begin
      dec_prefix[dec_next_free] = dec_prev[11:0];
      dec_suffix[dec_next_free] = root;
      dec_next_free++;
    end
    dec_prev = code;
    if (dec_next_free >= dec_bump && dec_width < MaxCodeBits) begin
      dec_width++;
      dec_bump = dec_bump << 1;
    end
  endfunction

  function automatic word_out_t predict_word(word_in_t w);
    word_out_t r;
    r = '0;
    if (w.cmd == CmdOffer) begin
      if (!dec_done && dec_count <= 16) begin
        dec_buf = dec_buf | (24'(w.data) << dec_count);
        dec_count += 8;
        r.accepted = 1'b1;
      end
    end else begin
      while (dec_depth == 0 && !dec_done && dec_count >= dec_width) decode_code();
      if (dec_depth > 0) begin
        dec_depth--;
        r.out_valid = 1'b1;
        r.out_byte = dec_stack[dec_depth];
      end
    end
    r.finished = dec_done;
    return r;
  endfunction

  function automatic void queue_word(logic cmd, logic [7:0] data);
    word_in_t w;
    w.cmd = cmd;
    w.data = data;
    pending_words.push_back(w);
    expected_words.push_back(predict_word(w));
  endfunction

  // Appends one code to the packed stream at the width the decoder will use.
  function automatic void emit_code(int code);
    pack_bits = pack_bits | (32'(code) << pack_count);
    pack_count += gen_width;
    while (pack_count >= 8) begin
      stream_bytes.push_back(pack_bits[7:0]);
      pack_bits = pack_bits >> 8;
      pack_count -= 8;
    end
    if (gen_after_clear) begin
      gen_after_clear = 0;
    end else if (code == CodeClear) begin
      gen_width = FirstWidth;
      gen_next_free = FirstFree;
      gen_bump = FirstBump;
      gen_after_clear = 1;
    end else if (code != CodeEnd) begin
      if (gen_next_free < DictEntries) gen_next_free++;
      if (gen_next_free >= gen_bump && gen_width < MaxCodeBits) begin
        gen_width++;
        gen_bump = gen_bump << 1;
      end
    end
  endfunction

  // Random well-formed code. A literal right after a clear stays below 256,
  // and dictionary codes stay at or below the next free entry.
  function automatic void emit_random_code(bit literals_mostly);
    int pick;
    pick = $urandom_range(99);
    if (gen_after_clear) begin
      emit_code($urandom_range(255));
    end else if (literals_mostly) begin
      if (pick < 85 || gen_next_free == FirstFree) emit_code($urandom_range(255));
      else emit_code($urandom_range(gen_next_free - 1, FirstFree));
    end else if (pick < 3) begin
      emit_code(CodeClear);
    end else if (pick < 15 && gen_next_free < DictEntries) begin
      emit_code(gen_next_free);
    end else if (pick < 55 && gen_next_free > FirstFree) begin
      emit_code($urandom_range(gen_next_free - 1, FirstFree));
    end else begin
      emit_code($urandom_range(255));
    end
  endfunction

  // Mixes offers of the next stream byte with pulls. Some offers are made
  // while the bit buffer is full; those are refused and the byte is kept.
  function automatic void stream_words(int count, bit literals_mostly);
    bit room;
    repeat (count) begin
      if (stream_bytes.size() < 2) emit_random_code(literals_mostly);
      room = !dec_done && dec_count <= 16;
      if (!room && $urandom_range(99) < 10) begin
        queue_word(CmdOffer, 8'($urandom_range(255)));
      end else if (!room || $urandom_range(99) < 45) begin
        queue_word(CmdPull, 8'($urandom_range(255)));
      end else begin
        queue_word(CmdOffer, stream_bytes.pop_front());
      end
    end
  endfunction

  // Offers what is left of the stream and pulls until the stack is empty.
  // Bytes that follow the end code can no longer be taken and stay behind.
  function automatic void flush_stream();
    int guard;
    guard = 0;
    while (((stream_bytes.size() > 0 && !dec_done) || dec_depth > 0) && guard < 20000) begin
      if (stream_bytes.size() > 0 && !dec_done && dec_count <= 16 &&
          $urandom_range(1)) begin
        queue_word(CmdOffer, stream_bytes.pop_front());
      end else begin
        queue_word(CmdPull, 8'($urandom_range(255)));
      end
      guard++;
    end
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || expected_words.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Driver: a new word is put up only when the channel is free or the word
  // on it is taken at this edge.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      command <= CmdOffer;
      in_byte <= 8'h00;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        command <= pending_words[0].cmd;
        in_byte <= pending_words[0].data;
        void'(pending_words.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
    end else if (stall_left > 0) begin
      res_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res_ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // Monitor: each result word is checked against the oldest prediction.
  always @(posedge clk) begin
    word_out_t want;
    if (rst_n && res_valid && res_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
      end else begin
        want = expected_words.pop_front();
        if (accepted !== want.accepted) report_mismatch("accepted", accepted, want.accepted);
        if (out_valid !== want.out_valid)
          report_mismatch("out_valid", out_valid, want.out_valid);
        if (out_byte !== want.out_byte) report_mismatch("out_byte", out_byte, want.out_byte);
        if (finished !== want.finished) report_mismatch("finished", finished, want.finished);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    dec_buf = '0;
    dec_count = 0;
    dec_width = FirstWidth;
    dec_next_free = FirstFree;
    dec_bump = FirstBump;
    dec_prev = 0;
    dec_first_char = '0;
    dec_after_clear = 0;
    dec_done = 0;
    dec_depth = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: pulls with nothing buffered, a start without a clear,
    // literals at both ends, a dictionary code, KwKwK, a clear followed by a
    // literal, and offers refused while the bit buffer is full.
    queue_word(CmdPull, 8'h00);
    queue_word(CmdPull, 8'hFF);
    emit_code(255);
    emit_code(0);
    emit_code(FirstFree);
    emit_code(gen_next_free);
    emit_code(CodeClear);
    emit_code(128);
    emit_code(gen_next_free);
    emit_code(gen_next_free - 1);
    repeat (3) queue_word(CmdOffer, stream_bytes.pop_front());
    queue_word(CmdOffer, 8'hFF);
    queue_word(CmdOffer, 8'h00);
    flush_stream();
    wait_drained();

    stream_words(350, 0);
    wait_drained();

    send_idle_pct = 60;
    stream_words(350, 0);
    wait_drained();

    // Receiver holds off for a long stretch while words keep coming.
    send_idle_pct = 0;
    recv_stall_pct = 60;
    stream_words(350, 0);
    stall_left = 300;
    wait_drained();

    send_idle_pct = 25;
    recv_stall_pct = 25;
    stream_words(350, 0);
    wait_drained();

    // A stretch of mostly literal codes with no idling.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stream_words(100, 1);
    flush_stream();

    // End of stream, padded out to a whole byte, then words after finish.
    emit_code(CodeEnd);
    if (pack_count > 0) emit_code(0);
    flush_stream();
    queue_word(CmdPull, 8'h00);
    queue_word(CmdOffer, 8'hA5);
    queue_word(CmdPull, 8'h00);
    wait_drained();
    repeat (50) @(posedge clk);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
